### design/smm_pkg.sv
package smm_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int DEF_ELEM_W  = 16;

  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 2;
  localparam int IDX_PORT_W = 3;
  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 34;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  // control flags that travel with one A element down the chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } smm_ctl_t;

endpackage

### design/smm_cell.sv
module smm_cell #(
  parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM,
  parameter int ELEM_W  = smm_pkg::DEF_ELEM_W,
  parameter int IW      = 3,
  parameter int AW      = 2 * ELEM_W + 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     b_we_i,
  input  logic [IW-1:0]            b_addr_i,
  input  logic signed [ELEM_W-1:0] b_data_i,
  input  smm_pkg::smm_ctl_t        ctl_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic [IW-1:0]            k_i,
  input  logic [IW-1:0]            row_i,
  output smm_pkg::smm_ctl_t        ctl_o,
  output logic signed [ELEM_W-1:0] a_o,
  output logic [IW-1:0]            k_o,
  output logic [IW-1:0]            row_o,
  output logic                     done_o,
  output logic signed [AW-1:0]     acc_o,
  output logic [IW-1:0]            res_row_o,
  output logic                     busy_o
);

  logic signed [ELEM_W-1:0]   bcol_q [MAX_DIM];
  smm_pkg::smm_ctl_t          ctl_q;
  logic signed [ELEM_W-1:0]   a_q;
  logic [IW-1:0]              k_q, row_q;
  logic signed [2*ELEM_W-1:0] prod_d, prod_q;
  logic                       pv_q, pfirst_q, plast_q;
  logic [IW-1:0]              prow_q, rrow_q;
  logic signed [AW-1:0]       acc_d, acc_q;
  logic                       done_q;

  // local column of B
  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      bcol_q[b_addr_i] <= b_data_i;
    end
  end

  assign prod_d = a_i * bcol_q[k_i];
  assign acc_d  = pfirst_q ? AW'(prod_q) : acc_q + AW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      pv_q   <= ctl_i.valid;
      done_q <= pv_q & plast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_i;
    k_q      <= k_i;
    row_q    <= row_i;
    prod_q   <= prod_d;
    pfirst_q <= ctl_i.first;
    plast_q  <= ctl_i.last;
    prow_q   <= row_i;
    if (pv_q) begin
      acc_q  <= acc_d;
      rrow_q <= prow_q;
    end
  end

  assign ctl_o     = ctl_q;
  assign a_o       = a_q;
  assign k_o       = k_q;
  assign row_o     = row_q;
  assign done_o    = done_q;
  assign acc_o     = acc_q;
  assign res_row_o = rrow_q;
  assign busy_o    = ctl_q.valid | pv_q | done_q;

endmodule

### design/small_matrix_multiply.sv
// Load beats produce no result. A start beat streams each row of A
// through a chain of MAX_DIM cells, one per column of B, issuing the rows
// one after another; a row's cols_b products leave back to back.
// Reset clears control and sets the sizes to 8, not the stores; results cannot stall.
module small_matrix_multiply #(
  parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM,
  parameter int ELEM_W  = smm_pkg::DEF_ELEM_W
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [smm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [smm_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [smm_pkg::MODE_W-1:0]            mode_i,
  input  logic [smm_pkg::IDX_PORT_W-1:0]        row_i,
  input  logic [smm_pkg::IDX_PORT_W-1:0]        col_i,
  input  logic signed [smm_pkg::VALUE_W-1:0]    value_i,
  output logic                                  out_valid_o,
  output logic [smm_pkg::IDX_PORT_W-1:0]        out_row_o,
  output logic [smm_pkg::IDX_PORT_W-1:0]        out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0]     product_o,
  output logic                                  last_o
);

  localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW  = $clog2(MAX_DIM + 1);
  localparam int AAW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int AW  = 2 * ELEM_W + 4;
  localparam int PW  = smm_pkg::PROD_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // size registers
  logic [smm_pkg::CFG_W-1:0] rows_q, inner_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= smm_pkg::DIM_RESET;
      inner_q <= smm_pkg::DIM_RESET;
      cols_q  <= smm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smm_pkg::REG_ROWS_A:     rows_q  <= cfg_data_i;
        smm_pkg::REG_INNER_SIZE: inner_q <= cfg_data_i;
        smm_pkg::REG_COLS_B:     cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..MAX_DIM
  logic [CW-1:0] nr_c, nk_c, nc_c;
  assign nr_c = (rows_q == '0) ? CW'(1) :
                (rows_q > smm_pkg::CFG_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(rows_q);
  assign nk_c = (inner_q == '0) ? CW'(1) :
                (inner_q > smm_pkg::CFG_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(inner_q);
  assign nc_c = (cols_q == '0) ? CW'(1) :
                (cols_q > smm_pkg::CFG_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(cols_q);

  // input beat decode
  logic acc_beat, in_range, load_a, load_b, go;
  logic [IW-1:0] ld_row, ld_col;
  logic [AAW-1:0] ld_addr;
  logic signed [ELEM_W-1:0] elem;

  assign acc_beat = start & ~busy;
  assign in_range = ({1'b0, row_i} < 4'(MAX_DIM)) && ({1'b0, col_i} < 4'(MAX_DIM));
  assign load_a   = acc_beat && in_range && (mode_i == smm_pkg::MODE_LOAD_A);
  assign load_b   = acc_beat && in_range && (mode_i == smm_pkg::MODE_LOAD_B);
  assign go       = acc_beat && (mode_i == smm_pkg::MODE_START);
  assign ld_row   = row_i[IW-1:0];
  assign ld_col   = col_i[IW-1:0];
  assign ld_addr  = AAW'(int'(ld_row) * MAX_DIM + int'(ld_col));

  generate
    if (ELEM_W <= smm_pkg::VALUE_W) begin : g_elem_cut
      assign elem = value_i[ELEM_W-1:0];
    end else begin : g_elem_ext
      assign elem = {{(ELEM_W - smm_pkg::VALUE_W){value_i[smm_pkg::VALUE_W-1]}}, value_i};
    end
  endgenerate

  // row sequencer
  logic          st_q;
  logic [IW-1:0] i_q;
  logic [CW-1:0] t_q, nr_q, nk_q, nc_q, period;
  logic          issue;
  logic [AAW-1:0] rd_addr;

  assign period  = (nk_q > nc_q) ? nk_q : nc_q;
  assign issue   = (st_q == ST_RUN) && (t_q < nk_q);
  assign rd_addr = AAW'(int'(i_q) * MAX_DIM + int'(t_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      i_q  <= '0;
      t_q  <= '0;
      nr_q <= CW'(1);
      nk_q <= CW'(1);
      nc_q <= CW'(1);
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (go) begin
            st_q <= ST_RUN;
            i_q  <= '0;
            t_q  <= '0;
            nr_q <= nr_c;
            nk_q <= nk_c;
            nc_q <= nc_c;
          end
        end
        ST_RUN: begin
          if (t_q == period - CW'(1)) begin
            t_q <= '0;
            if (CW'(i_q) == nr_q - CW'(1)) begin
              st_q <= ST_IDLE;
            end else begin
              i_q <= i_q + IW'(1);
            end
          end else begin
            t_q <= t_q + CW'(1);
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // A store, registered read feeds the head of the chain
  logic signed [ELEM_W-1:0] amem_q [MAX_DIM * MAX_DIM];
  logic signed [ELEM_W-1:0] a_rd_q;
  smm_pkg::smm_ctl_t        head_ctl_q;
  logic [IW-1:0]            head_k_q, head_row_q;

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      amem_q[ld_addr] <= elem;
    end
    if (issue) begin
      a_rd_q <= amem_q[rd_addr];
    end
    head_k_q   <= t_q[IW-1:0];
    head_row_q <= i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ctl_q <= '0;
    end else begin
      head_ctl_q.valid <= issue;
      head_ctl_q.first <= (t_q == '0);
      head_ctl_q.last  <= (t_q == nk_q - CW'(1));
    end
  end

  // cell chain: A element hops one cell per cycle
  smm_pkg::smm_ctl_t        ctl_w [MAX_DIM+1];
  logic signed [ELEM_W-1:0] a_w   [MAX_DIM+1];
  logic [IW-1:0]            k_w   [MAX_DIM+1];
  logic [IW-1:0]            row_w [MAX_DIM+1];
  logic                     done_w [MAX_DIM];
  logic signed [AW-1:0]     acc_w  [MAX_DIM];
  logic [IW-1:0]            rrow_w [MAX_DIM];
  logic [MAX_DIM-1:0]       cbusy;
  logic [MAX_DIM-1:0]       emit;

  assign ctl_w[0] = head_ctl_q;
  assign a_w[0]   = a_rd_q;
  assign k_w[0]   = head_k_q;
  assign row_w[0] = head_row_q;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    smm_cell #(
      .MAX_DIM(MAX_DIM),
      .ELEM_W (ELEM_W),
      .IW     (IW),
      .AW     (AW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .b_we_i   (load_b && (ld_col == IW'(j))),
      .b_addr_i (ld_row),
      .b_data_i (elem),
      .ctl_i    (ctl_w[j]),
      .a_i      (a_w[j]),
      .k_i      (k_w[j]),
      .row_i    (row_w[j]),
      .ctl_o    (ctl_w[j+1]),
      .a_o      (a_w[j+1]),
      .k_o      (k_w[j+1]),
      .row_o    (row_w[j+1]),
      .done_o   (done_w[j]),
      .acc_o    (acc_w[j]),
      .res_row_o(rrow_w[j]),
      .busy_o   (cbusy[j])
    );
    // only columns inside cols_b produce results
    assign emit[j] = done_w[j] && (CW'(j) < nc_q);
  end

  // pick the cell that finished this cycle; at most one per cycle
  logic                 sel;
  logic signed [AW-1:0] sel_acc;
  logic [IW-1:0]        sel_row, sel_col;
  logic signed [PW-1:0] sat;

  always_comb begin
    sel     = 1'b0;
    sel_acc = '0;
    sel_row = '0;
    sel_col = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (emit[j]) begin
        sel     = 1'b1;
        sel_acc = acc_w[j];
        sel_row = rrow_w[j];
        sel_col = IW'(j);
      end
    end
  end

  generate
    if (AW > PW) begin : g_sat
      localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (PW - 1)) - 64'sd1);
      localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
      always_comb begin
        if (sel_acc > SAT_HI) begin
          sat = SAT_HI[PW-1:0];
        end else if (sel_acc < SAT_LO) begin
          sat = SAT_LO[PW-1:0];
        end else begin
          sat = sel_acc[PW-1:0];
        end
      end
    end else begin : g_ext
      assign sat = {{(PW - AW){sel_acc[AW-1]}}, sel_acc};
    end
  endgenerate

  // result register: one beat per cycle, no backpressure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= sel;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_o <= smm_pkg::IDX_PORT_W'(sel_row);
    out_col_o <= smm_pkg::IDX_PORT_W'(sel_col);
    product_o <= sat;
    last_o    <= sel && (CW'(sel_row) == nr_q - CW'(1)) && (CW'(sel_col) == nc_q - CW'(1));
  end

  // hold off new beats while anything is in flight
  assign busy = (st_q == ST_RUN) | head_ctl_q.valid | (|cbusy) | ctl_w[MAX_DIM].valid;

  // checks
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(emit))
    else $error("two columns finished in the same cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy)
    else $error("start beat did not raise busy");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o)
    else $error("last flag without a result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !out_valid_o)
    else $error("result while idle");

endmodule
